@@ src/bheh_pkg.sv @@
// Shared types, constants and the control program of the button event history encoder.
`timescale 1ns / 1ps

package bheh_pkg;

    localparam int HISTORY_DEPTH = 8;
    localparam int HIST_IDX_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HIST_CNT_W    = $clog2(HISTORY_DEPTH + 1);

    localparam int BUTTON_COUNT  = 17;
    localparam int BTN_IDX_W     = 5;
    localparam logic [BTN_IDX_W-1:0] BTN_LAST        = BTN_IDX_W'(BUTTON_COUNT - 1);
    localparam logic [BTN_IDX_W-1:0] STATE_CODE_FIRST = BTN_IDX_W'(12);

    localparam logic [7:0] EVENT_LEAD  = 8'h80;
    localparam logic [7:0] PRESS_BIAS  = 8'h20;
    localparam logic [7:0] PRESS_FLAG  = 8'hff;
    localparam logic [7:0] MAX_BYTES_RESET = 8'hff;

    // history entry: button index and pressed flag; bytes are rebuilt on read
    typedef struct packed {
        logic                 pressed;
        logic [BTN_IDX_W-1:0] idx;
    } hist_entry_t;

    localparam int PC_W = 3;

    typedef enum logic [2:0] {
        OP_NOP      = 3'd0,
        OP_ACCEPT   = 3'd1,
        OP_SCAN     = 3'd2,
        OP_SUM_CLR  = 3'd3,
        OP_SUM      = 3'd4,
        OP_EMIT_CLR = 3'd5,
        OP_EMIT     = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER      = 3'd0,
        C_NO_WORK    = 3'd1,
        C_SCAN_MORE  = 3'd2,
        C_SUM_FIT    = 3'd3,
        C_TOTAL_ZERO = 3'd4,
        C_EMIT_MORE  = 3'd5
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] jump;
        logic [PC_W-1:0] next;
    } ctrl_word_t;

    function automatic ctrl_word_t prog_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t cw;
        begin
            unique case (pc)
                3'd0:    cw = '{OP_ACCEPT,   C_NO_WORK,    3'd0, 3'd1};
                3'd1:    cw = '{OP_SCAN,     C_SCAN_MORE,  3'd1, 3'd2};
                3'd2:    cw = '{OP_SUM_CLR,  C_NEVER,      3'd0, 3'd3};
                3'd3:    cw = '{OP_SUM,      C_SUM_FIT,    3'd3, 3'd4};
                3'd4:    cw = '{OP_EMIT_CLR, C_TOTAL_ZERO, 3'd0, 3'd5};
                3'd5:    cw = '{OP_EMIT,     C_EMIT_MORE,  3'd5, 3'd0};
                default: cw = '{OP_NOP,      C_NEVER,      3'd0, 3'd0};
            endcase
            return cw;
        end
    endfunction

    function automatic logic [7:0] button_code(input logic [BTN_IDX_W-1:0] idx);
        logic [7:0] code;
        begin
            case (idx)
                5'd0:    code = 8'h88;
                5'd1:    code = 8'h89;
                5'd2:    code = 8'h8a;
                5'd3:    code = 8'h8b;
                5'd4:    code = 8'h80;
                5'd5:    code = 8'h81;
                5'd6:    code = 8'h82;
                5'd7:    code = 8'h83;
                5'd8:    code = 8'h84;
                5'd9:    code = 8'h85;
                5'd10:   code = 8'h86;
                5'd11:   code = 8'h87;
                5'd12:   code = 8'h8c;
                5'd13:   code = 8'h8d;
                5'd14:   code = 8'h8e;
                5'd15:   code = 8'h8f;
                5'd16:   code = 8'h90;
                default: code = 8'h00;
            endcase
            return code;
        end
    endfunction

    function automatic logic [1:0] event_len(input hist_entry_t ent);
        begin
            return (ent.idx >= STATE_CODE_FIRST) ? 2'd2 : 2'd3;
        end
    endfunction

    function automatic logic [7:0] event_byte(input hist_entry_t ent, input logic [1:0] j);
        logic [7:0] b;
        begin
            case (j)
                2'd0:    b = EVENT_LEAD;
                2'd1:    b = (ent.idx >= STATE_CODE_FIRST && ent.pressed)
                             ? button_code(ent.idx) + PRESS_BIAS : button_code(ent.idx);
                default: b = ent.pressed ? PRESS_FLAG : 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage

@@ src/button_event_history_encoder.sv @@
// Top level: button event history encoder run by a small microcoded sequencer.
`timescale 1ns / 1ps

// Takes one 17-bit button frame per item and, when any button changed since the
// previous frame, streams the newest-first event history as bytes, last_byte
// marking the final one. The first frame after reset and frames with no change
// give no output. Otherwise a six-step control program runs: it takes the
// frame, walks the buttons one per cycle (pushing an event for each changed
// one into a circular history of 8 entries), sizes the payload over the
// events that fit, then sends one byte per cycle when the output is not stalled.
// A new frame is taken only in the first step. max_payload_bytes may be written
// at any time the block is idle.
module button_event_history_encoder
    import bheh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [16:0] button_bits,
    input  logic        in_valid,
    output logic        in_stall,
    output logic [7:0]  payload_byte,
    output logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  max_payload_bytes,
    input  logic        cfg_valid,
    output logic        cfg_ready
);

    logic [PC_W-1:0]        pc_reg, pc_next;
    logic [7:0]             max_bytes_reg;
    logic [16:0]            prior_reg;
    logic                   seen_reg;
    logic [16:0]            changed_reg;
    logic [BTN_IDX_W-1:0]   btn_reg;
    logic [HIST_IDX_W-1:0]  head_reg;
    logic [HIST_CNT_W-1:0]  held_reg;
    logic [HIST_CNT_W-1:0]  evt_reg;
    logic [1:0]             byte_reg;
    logic [7:0]             total_reg;
    logic [7:0]             sent_reg;
    logic                   out_valid_reg;
    logic [7:0]             out_byte_reg;
    logic                   out_last_reg;
    hist_entry_t            hist_mem [HISTORY_DEPTH];

    ctrl_word_t             cw;
    logic                   cond_true;
    logic [16:0]            frame_diff;
    logic                   accept;
    logic                   no_work;
    logic                   push;
    logic [HIST_IDX_W-1:0]  head_dec;
    logic [HIST_IDX_W:0]    rd_sum;
    logic [HIST_IDX_W-1:0]  rd_addr;
    hist_entry_t            rd_ent;
    logic [1:0]             rd_len;
    logic [8:0]             sum_try;
    logic                   sum_fit;
    logic                   out_free;
    logic                   emit_fire;
    logic                   emit_last;

    assign cw         = prog_rom(pc_reg);
    assign in_stall   = (cw.op != OP_ACCEPT);
    assign accept     = in_valid && !in_stall;
    assign frame_diff = prior_reg ^ button_bits;
    assign no_work    = !in_valid || !seen_reg || (frame_diff == '0);

    assign push     = (cw.op == OP_SCAN) && changed_reg[btn_reg];
    assign head_dec = (head_reg == '0) ? HIST_IDX_W'(HISTORY_DEPTH - 1)
                                       : head_reg - 1'b1;

    // entry e sits e places after the head, wrapping round the ring
    assign rd_sum  = {1'b0, head_reg} + {1'b0, evt_reg[HIST_IDX_W-1:0]};
    assign rd_addr = (rd_sum >= (HIST_IDX_W+1)'(HISTORY_DEPTH))
                     ? HIST_IDX_W'(rd_sum - (HIST_IDX_W+1)'(HISTORY_DEPTH))
                     : rd_sum[HIST_IDX_W-1:0];
    assign rd_ent  = hist_mem[rd_addr];
    assign rd_len  = event_len(rd_ent);

    assign sum_try = {1'b0, total_reg} + {7'd0, rd_len};
    assign sum_fit = (evt_reg < held_reg) && (sum_try <= {1'b0, max_bytes_reg});

    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_fire = (cw.op == OP_EMIT) && out_free;
    assign emit_last = (sent_reg == total_reg - 8'd1);

    always_comb
    begin
        unique case (cw.cond)
            C_NEVER:      cond_true = 1'b0;
            C_NO_WORK:    cond_true = no_work;
            C_SCAN_MORE:  cond_true = (btn_reg != BTN_LAST);
            C_SUM_FIT:    cond_true = sum_fit;
            C_TOTAL_ZERO: cond_true = (total_reg == '0);
            C_EMIT_MORE:  cond_true = !(emit_fire && emit_last);
            default:      cond_true = 1'b0;
        endcase
        pc_next = cond_true ? cw.jump : cw.next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            max_bytes_reg <= MAX_BYTES_RESET;
            prior_reg     <= '0;
            seen_reg      <= 1'b0;
            changed_reg   <= '0;
            btn_reg       <= '0;
            head_reg      <= '0;
            held_reg      <= '0;
            evt_reg       <= '0;
            byte_reg      <= '0;
            total_reg     <= '0;
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;

            if (cfg_valid)
            begin
                max_bytes_reg <= max_payload_bytes;
            end

            if (accept)
            begin
                prior_reg   <= button_bits;
                seen_reg    <= 1'b1;
                changed_reg <= frame_diff;
                btn_reg     <= '0;
            end

            if (cw.op == OP_SCAN)
            begin
                btn_reg <= btn_reg + 1'b1;
            end

            if (push)
            begin
                head_reg <= head_dec;
                if (held_reg != HIST_CNT_W'(HISTORY_DEPTH))
                begin
                    held_reg <= held_reg + 1'b1;
                end
            end

            if (cw.op == OP_SUM_CLR)
            begin
                evt_reg   <= '0;
                total_reg <= '0;
            end

            if (cw.op == OP_SUM && sum_fit)
            begin
                evt_reg   <= evt_reg + 1'b1;
                total_reg <= sum_try[7:0];
            end

            if (cw.op == OP_EMIT_CLR)
            begin
                evt_reg  <= '0;
                byte_reg <= '0;
                sent_reg <= '0;
            end

            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
                sent_reg      <= sent_reg + 8'd1;
                if (byte_reg == rd_len - 2'd1)
                begin
                    byte_reg <= '0;
                    evt_reg  <= evt_reg + 1'b1;
                end
                else
                begin
                    byte_reg <= byte_reg + 2'd1;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            hist_mem[head_dec] <= '{pressed: prior_reg[btn_reg], idx: btn_reg};
        end
        if (emit_fire)
        begin
            out_byte_reg <= event_byte(rd_ent, byte_reg);
            out_last_reg <= emit_last;
        end
    end

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign payload_byte = out_byte_reg;
    assign last_byte    = out_last_reg;

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the button event history encoder: frame stimulus, byte checker.
`timescale 1ns / 1ps

module testbench;
    import bheh_pkg::*;

    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 25;
    localparam int IDLE_PCT      = 37;

    localparam logic [7:0] BTN_CODE [BUTTON_COUNT] = '{
        8'h88, 8'h89, 8'h8a, 8'h8b, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84,
        8'h85, 8'h86, 8'h87, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90
    };

    // Tracks button state and event history, queues the bytes each frame should send.
    class history_tracker;
        logic [16:0]      prior;
        bit               seen;
        int               limit;
        logic [2:0][7:0]  ev_bytes [HISTORY_DEPTH];
        int               ev_len [HISTORY_DEPTH];
        int               held;
        logic [8:0]       due_bytes [$];    // {last, byte}
        int               errors;

        function new();
            prior  = '0;
            seen   = 1'b0;
            limit  = MAX_BYTES_RESET;
            held   = 0;
            errors = 0;
        endfunction

        function void set_limit(logic [7:0] value);
            limit = value;
        endfunction

        function int pending();
            return due_bytes.size();
        endfunction

        function void take_frame(logic [16:0] now);
            logic [16:0] flips;
            int total;
            int fit;
            int sent;
            if (!seen) begin
                seen  = 1'b1;
                prior = now;
                return;
            end
            flips = prior ^ now;
            prior = now;
            if (flips == '0)
                return;
            for (int b = 0; b < BUTTON_COUNT; b++) begin
                if (flips[b]) begin
                    for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
                        ev_bytes[k] = ev_bytes[k-1];
                        ev_len[k]   = ev_len[k-1];
                    end
                    if (b >= STATE_CODE_FIRST) begin
                        ev_bytes[0] = {8'h00, BTN_CODE[b] + (now[b] ? PRESS_BIAS : 8'h00),
                                       EVENT_LEAD};
                        ev_len[0]   = 2;
                    end
                    else begin
                        ev_bytes[0] = {(now[b] ? PRESS_FLAG : 8'h00), BTN_CODE[b], EVENT_LEAD};
                        ev_len[0]   = 3;
                    end
                    if (held < HISTORY_DEPTH)
                        held++;
                end
            end
            // whole events only; anything behind the first that overflows is dropped
            total = 0;
            fit   = 0;
            while (fit < held && total + ev_len[fit] <= limit) begin
                total += ev_len[fit];
                fit++;
            end
            sent = 0;
            for (int e = 0; e < fit; e++) begin
                for (int j = 0; j < ev_len[e]; j++) begin
                    sent++;
                    due_bytes.push_back({sent == total, ev_bytes[e][j]});
                end
            end
        endfunction

        function void match_byte(logic [7:0] data, logic last);
            logic [8:0] want;
            if (due_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected byte, expected none, actual %h last %b",
                         $time, data, last);
                return;
            end
            want = due_bytes.pop_front();
            if (data !== want[7:0]) begin
                errors++;
                $display("%0t: payload_byte expected %h actual %h", $time, want[7:0], data);
            end
            if (last !== want[8]) begin
                errors++;
                $display("%0t: last_byte expected %b actual %b", $time, want[8], last);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [16:0] button_bits = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  max_payload_bytes = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;

    bit steady = 1'b0;
    bit hold_req = 1'b0;

    history_tracker sb;

    button_event_history_encoder u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .button_bits       (button_bits),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .payload_byte      (payload_byte),
        .last_byte         (last_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .max_payload_bytes (max_payload_bytes),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready)
    );

    always #1 clk = ~clk;

    // Handshakes are sampled mid-cycle, well clear of the driving edge.
    initial
    begin : monitor
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(negedge clk);
            quiet++;
            if (in_valid && !in_stall)
            begin
                sb.take_frame(button_bits);
                quiet = 0;
            end
            if (out_valid && !out_stall)
            begin
                sb.match_byte(payload_byte, last_byte);
                quiet = 0;
            end
            if (cfg_valid && cfg_ready)
            begin
                sb.set_limit(max_payload_bytes);
                quiet = 0;
            end
        end
        $display("testbench: errors");
        $finish;
    end

    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic send_frame(input logic [16:0] bits);
        bit taken;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        button_bits <= bits;
        do
        begin
            @(negedge clk);
            taken = in_valid && !in_stall;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic write_limit(input logic [7:0] value);
        bit taken;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid         <= 1'b1;
        max_payload_bytes <= value;
        do
        begin
            @(negedge clk);
            taken = cfg_valid && cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
    endtask

    // Mostly one or two buttons moving, some repeats, some whole new frames.
    function automatic logic [16:0] next_frame(input logic [16:0] cur);
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return cur;
        if (pick < 65)
            return cur ^ (17'd1 << $urandom_range(16));
        if (pick < 85)
            return cur ^ (17'd1 << $urandom_range(16)) ^ (17'd1 << $urandom_range(16));
        return 17'($urandom);
    endfunction

    initial
    begin : stimulus
        logic [16:0] frame;
        logic [7:0]  limits [10];
        sb = new();
        limits = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd8, 8'd13, 8'd24, 8'd255, 8'd0};
        limits[9] = 8'($urandom_range(4, 40));
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first frame only records; then all released, a repeat, all pressed
        send_frame(17'h1ffff);
        send_frame(17'h00000);
        send_frame(17'h00000);
        frame = 17'h1ffff;
        send_frame(frame);
        // release each button alone, both event forms
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            frame = frame ^ (17'd1 << i);
            send_frame(frame);
        end
        send_frame(17'h0aaaa);
        frame = 17'h15555;
        send_frame(frame);

        for (int p = 0; p < 10; p++)
        begin
            in_valid <= 1'b0;
            write_limit(limits[p]);
            steady = (p == 7);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 8 && n == 5)
                    hold_req = 1'b1;
                frame = next_frame(frame);
                send_frame(frame);
            end
            steady = 1'b0;
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
